/* rtl/lmc_pkg.sv */
`default_nettype none

package lmc_pkg;

  // Field widths fixed by the instruction set and the item format.
  localparam int WordW = 11;
  localparam int AddrW = 7;
  localparam int CodeW = 10;
  localparam int MailboxCount = 100;

  // Decimal constants of the machine.
  localparam logic signed [WordW:0] WordMax  = 12'sd999;
  localparam logic signed [WordW:0] WrapSpan = 12'sd1999;
  localparam logic [CodeW-1:0] CodeBase = 10'd900;
  localparam logic [CodeW-1:0] CodeInp  = 10'd901;
  localparam logic [CodeW-1:0] CodeOut  = 10'd902;
  localparam logic [CodeW-1:0] CharInReset  = 10'd923;
  localparam logic [CodeW-1:0] CharOutReset = 10'd922;

  // Division by 100 of a word below 1000: multiply by 41, drop 12 bits.
  localparam logic [15:0] HundredRecip = 16'd41;
  localparam int HundredShift = 12;
  localparam logic [CodeW-1:0] Hundred = 10'd100;

  // Opcodes (hundreds digit of an instruction word).
  localparam logic [3:0] OpHlt = 4'd0;
  localparam logic [3:0] OpAdd = 4'd1;
  localparam logic [3:0] OpSub = 4'd2;
  localparam logic [3:0] OpSta = 4'd3;
  localparam logic [3:0] OpLda = 4'd5;
  localparam logic [3:0] OpBra = 4'd6;
  localparam logic [3:0] OpBrz = 4'd7;
  localparam logic [3:0] OpBrp = 4'd8;
  localparam logic [3:0] OpIo  = 4'h9;

  // Output kinds.
  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindNum  = 2'd1;
  localparam logic [1:0] KindChar = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] RegCharIn  = 2'd0;
  localparam logic [1:0] RegCharOut = 2'd1;

  typedef enum logic [1:0] {
    ActClear = 2'd0,
    ActLoad  = 2'd1,
    ActStep  = 2'd2,
    ActNone  = 2'd3
  } action_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic simple;  // clear, load or no-op transaction, finished this cycle
    logic fetch;   // read the instruction word at the program counter
    logic decode;  // split the word and read the operand mailbox
    logic exec;    // update accumulator, program counter and memory
  } lmc_cmd_t;

  // Fold a sum back into -999..999 by 1999.
  function automatic logic signed [WordW-1:0] wrap_word(input logic signed [WordW:0] v);
    logic signed [WordW:0] r;
    r = v;
    if (v > WordMax) begin
      r = v - WrapSpan;
    end else if (v < -WordMax) begin
      r = v + WrapSpan;
    end
    return r[WordW-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/lmc_ram.sv */
`default_nettype none

module lmc_ram #(
  parameter int Width = 11,
  parameter int Depth = 100
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/lmc_ctrl.sv */
`default_nettype none

module lmc_ctrl
  import lmc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  input  wire action_e  action_i,
  output logic          busy,
  output lmc_cmd_t      cmd_o,
  output logic          done_o
);

  typedef enum logic [1:0] {
    StIdle,
    StFetch,
    StExec
  } state_e;

  state_e state_q;
  logic   done_q;
  logic   accept;

  assign busy   = (state_q != StIdle);
  assign accept = start && (state_q == StIdle);
  assign done_o = done_q;

  // Commands follow the state and a newly accepted transaction.
  always_comb begin
    cmd_o        = '0;
    cmd_o.simple = accept && (action_i != ActStep);
    cmd_o.fetch  = accept && (action_i == ActStep);
    cmd_o.decode = (state_q == StFetch);
    cmd_o.exec   = (state_q == StExec);
  end

  // State and the registered result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      // A result follows a clear, load or report transaction or the end of a step.
      done_q <= (state_q == StExec) || (accept && (action_i != ActStep));
      case (state_q)
        StIdle: begin
          if (accept && (action_i == ActStep)) begin
            state_q <= StFetch;
          end
        end
        StFetch: begin
          state_q <= StExec;
        end
        StExec: begin
          state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // An accepted step walks fetch, execute and then reports.
  a_step_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i == ActStep) |=> (state_q == StFetch))
    else $error("step transaction did not enter fetch");

  a_fetch_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFetch) |=> (state_q == StExec))
    else $error("fetch not followed by execute");

  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec) |=> (done_q && state_q == StIdle))
    else $error("execute did not report a result");

endmodule

`default_nettype wire

/* rtl/lmc_datapath.sv */
`default_nettype none

module lmc_datapath
  import lmc_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire lmc_cmd_t                cmd_i,
  input  wire action_e                 action_i,
  input  wire logic [AddrW-1:0]        word_address_i,
  input  wire logic signed [WordW-1:0] word_value_i,
  input  wire logic signed [WordW-1:0] in_value_i,
  input  wire logic                    cfg_we_i,
  input  wire logic [1:0]              cfg_index_i,
  input  wire logic [CodeW-1:0]        cfg_data_i,
  output logic                         halted_o,
  output logic [1:0]                   out_kind_o,
  output logic signed [WordW-1:0]      out_value_o,
  output logic [AddrW-1:0]             next_pc_o,
  output logic signed [WordW-1:0]      acc_value_o
);

  // Architectural state.
  logic signed [WordW-1:0] acc_q, acc_d;
  logic [AddrW-1:0]        pc_q, pc_d;
  logic [CodeW-1:0]        char_in_q, char_out_q;
  logic [MailboxCount-1:0] valid_q;
  logic                    rvalid_q;

  // Per-instruction holding registers.
  logic signed [WordW-1:0] inval_q;
  logic [3:0]              op_q;
  logic [AddrW-1:0]        addr_q;
  logic                    neg_q;

  // Result registers.
  logic                    halted_q, halted_d;
  logic [1:0]              kind_q, kind_d;
  logic signed [WordW-1:0] oval_q, oval_d;

  // Memory port signals.
  logic                    ram_we;
  logic [AddrW-1:0]        ram_waddr;
  logic signed [WordW-1:0] ram_wdata;
  logic [AddrW-1:0]        ram_raddr;
  logic [WordW-1:0]        ram_rdata;
  logic signed [WordW-1:0] word;

  // Decode signals.
  logic [CodeW-1:0]        w10;
  logic [15:0]             prod;
  logic [3:0]              dec_op;
  logic [CodeW-1:0]        dec_rem;
  logic [CodeW-1:0]        code;
  logic [AddrW-1:0]        pc_inc;
  logic                    jumped;

  lmc_ram #(
    .Width(WordW),
    .Depth(MailboxCount)
  ) u_mailbox (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // A mailbox never written since the last clear reads as zero.
  assign word = rvalid_q ? $signed(ram_rdata) : '0;

  // Split a non-negative word into hundreds digit and mailbox address.
  assign w10     = word[CodeW-1:0];
  assign prod    = {6'b0, w10} * HundredRecip;
  assign dec_op  = prod[HundredShift +: 4];
  assign dec_rem = w10 - 10'({6'b0, dec_op} * Hundred);

  // The read port serves the fetch, then the operand.
  assign ram_raddr = cmd_i.decode ? dec_rem[AddrW-1:0] : pc_q;

  assign pc_inc = (pc_q == AddrW'(MailboxCount - 1)) ? '0 : pc_q + 1'b1;
  assign code   = CodeBase + {3'b0, addr_q};

  // Next state of accumulator, program counter, memory and result.
  always_comb begin
    acc_d     = acc_q;
    pc_d      = pc_q;
    halted_d  = 1'b0;
    kind_d    = KindNone;
    oval_d    = '0;
    ram_we    = 1'b0;
    ram_waddr = word_address_i;
    ram_wdata = wrap_word({word_value_i[WordW-1], word_value_i});
    jumped    = 1'b0;
    if (cmd_i.simple) begin
      case (action_i)
        ActClear: begin
          acc_d = '0;
          pc_d  = '0;
        end
        ActLoad: begin
          ram_we = (word_address_i < AddrW'(MailboxCount));
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.exec) begin
      ram_waddr = addr_q;
      ram_wdata = acc_q;
      if (!neg_q) begin
        case (op_q)
          OpHlt: begin
            halted_d = 1'b1;
            jumped   = 1'b1;
          end
          OpAdd: acc_d = wrap_word({acc_q[WordW-1], acc_q} + {word[WordW-1], word});
          OpSub: acc_d = wrap_word({acc_q[WordW-1], acc_q} - {word[WordW-1], word});
          OpSta: ram_we = 1'b1;
          OpLda: acc_d = word;
          OpBra: begin
            pc_d   = addr_q;
            jumped = 1'b1;
          end
          OpBrz: begin
            if (acc_q == '0) begin
              pc_d   = addr_q;
              jumped = 1'b1;
            end
          end
          OpBrp: begin
            if (!acc_q[WordW-1]) begin
              pc_d   = addr_q;
              jumped = 1'b1;
            end
          end
          OpIo: begin
            if (code == CodeInp) begin
              acc_d = wrap_word({inval_q[WordW-1], inval_q});
            end else if (code == CodeOut) begin
              kind_d = KindNum;
              oval_d = acc_q;
            end else if (code == char_in_q) begin
              acc_d = wrap_word({inval_q[WordW-1], inval_q});
            end else if (code == char_out_q) begin
              kind_d = KindChar;
              oval_d = acc_q;
            end
          end
          default: begin
          end
        endcase
      end
      if (!jumped) begin
        pc_d = pc_inc;
      end
    end
  end

  // Control state: accumulator, program counter, registers, valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      pc_q       <= '0;
      char_in_q  <= CharInReset;
      char_out_q <= CharOutReset;
      valid_q    <= '0;
    end else begin
      acc_q <= acc_d;
      pc_q  <= pc_d;
      if (cfg_we_i && cfg_index_i == RegCharIn) begin
        char_in_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == RegCharOut) begin
        char_out_q <= cfg_data_i;
      end
      if (cmd_i.simple && action_i == ActClear) begin
        valid_q <= '0;
      end else if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers: read validity, decoded fields, results.
  always_ff @(posedge clk_i) begin
    rvalid_q <= valid_q[ram_raddr];
    if (cmd_i.fetch) begin
      inval_q <= in_value_i;
    end
    if (cmd_i.decode) begin
      op_q   <= dec_op;
      addr_q <= dec_rem[AddrW-1:0];
      neg_q  <= word[WordW-1];
    end
    if (cmd_i.simple || cmd_i.exec) begin
      halted_q <= halted_d;
      kind_q   <= kind_d;
      oval_q   <= oval_d;
    end
  end

  assign halted_o    = halted_q;
  assign out_kind_o  = kind_q;
  assign out_value_o = oval_q;
  assign next_pc_o   = pc_q;
  assign acc_value_o = acc_q;

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.simple && action_i == ActClear) |=> (pc_q == '0 && acc_q == '0 && valid_q == '0))
    else $error("clear transaction left state behind");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q < AddrW'(MailboxCount))
    else $error("program counter beyond mailbox count");

  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_q <= 11'sd999) && (acc_q >= -11'sd999))
    else $error("accumulator outside decimal range");

endmodule

`default_nettype wire

/* rtl/little_man_computer_core.sv */
// Decimal accumulator machine with 100 signed mailboxes (-999..999).
// Command channel: a transaction is taken on a rising edge with start high
// and busy low. action selects clear (0), load one mailbox (1), execute the
// instruction at the program counter (2); action 3 only reports state.
// Result channel: result_valid_o is high for exactly one cycle per command,
// with halted_o, out_kind_o, out_value_o, next_pc_o and acc_value_o valid
// in that cycle. The receiver cannot stall; each result must be taken then.
// Latency: clear, load and report give their result in the cycle after the
// command and keep busy low, so one command can follow every cycle.
// A step runs instruction read, operand read and write-back in that order, all
// through the single port pair of the mailbox memory; its result shows in the
// cycle that busy falls, when the next command may already be given.
// Configuration: cfg_valid_i/cfg_ready_o write channel, index 0 is the
// character input code, index 1 the character output code; write only while
// the core is idle. Reset clears accumulator, program counter and all
// mailbox valid bits at once, so every mailbox reads zero without a sweep.
`default_nettype none

module little_man_computer_core
  import lmc_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              action_i,
  input  wire logic [AddrW-1:0]        word_address_i,
  input  wire logic signed [WordW-1:0] word_value_i,
  input  wire logic signed [WordW-1:0] in_value_i,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [1:0]              cfg_index_i,
  input  wire logic [CodeW-1:0]        cfg_data_i,
  output logic                         result_valid_o,
  output logic                         halted_o,
  output logic [1:0]                   out_kind_o,
  output logic signed [WordW-1:0]      out_value_o,
  output logic [AddrW-1:0]             next_pc_o,
  output logic signed [WordW-1:0]      acc_value_o
);

  lmc_cmd_t cmd;
  action_e  action;

  assign action      = action_e'(action_i);
  assign cfg_ready_o = 1'b1;

  lmc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .action_i(action),
    .busy    (busy),
    .cmd_o   (cmd),
    .done_o  (result_valid_o)
  );

  lmc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .action_i      (action),
    .word_address_i(word_address_i),
    .word_value_i  (word_value_i),
    .in_value_i    (in_value_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .halted_o      (halted_o),
    .out_kind_o    (out_kind_o),
    .out_value_o   (out_value_o),
    .next_pc_o     (next_pc_o),
    .acc_value_o   (acc_value_o)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench
  import lmc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Index that selects no register; writes to it must change nothing.
  localparam logic [1:0] RegUnused = 2'd3;
  localparam int PhaseItems = 200;
  localparam int MaxPrinted = 40;

  // One status report of the core.
  typedef struct packed {
    logic                    halted;
    logic [1:0]              kind;
    logic signed [WordW-1:0] value;
    logic [AddrW-1:0]        pc;
    logic signed [WordW-1:0] acc;
  } lmc_status_t;

  // One command, with an optional hand-written status that it must produce.
  typedef struct packed {
    action_e                 action;
    logic [AddrW-1:0]        addr;
    logic signed [WordW-1:0] wval;
    logic signed [WordW-1:0] ival;
    logic                    has_want;
    lmc_status_t             want;
  } cmd_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [1:0]              action_i;
  logic [AddrW-1:0]        word_address_i;
  logic signed [WordW-1:0] word_value_i;
  logic signed [WordW-1:0] in_value_i;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [1:0]              cfg_index_i;
  logic [CodeW-1:0]        cfg_data_i;
  logic                    result_valid_o;
  logic                    halted_o;
  logic [1:0]              out_kind_o;
  logic signed [WordW-1:0] out_value_o;
  logic [AddrW-1:0]        next_pc_o;
  logic signed [WordW-1:0] acc_value_o;

  // Machine state as the predictor sees it.
  int               mbox_model [MailboxCount];
  int               acc_model;
  int               pc_model;
  logic [CodeW-1:0] char_in_model;
  logic [CodeW-1:0] char_out_model;

  lmc_status_t expected_status_q[$];
  cmd_row_t    row_q;
  int          errors;
  int          accepted;
  int          checked;
  int          steps_run;
  int          halts_seen;
  int          num_outputs;
  int          char_outputs;

  little_man_computer_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .word_address_i (word_address_i),
    .word_value_i   (word_value_i),
    .in_value_i     (in_value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .halted_o       (halted_o),
    .out_kind_o     (out_kind_o),
    .out_value_o    (out_value_o),
    .next_pc_o      (next_pc_o),
    .acc_value_o    (acc_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Print the first few mismatches and count all of them.
  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MaxPrinted) begin
      $display("mismatch at %0t ns: %s is %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Fold a sum back into -999..999.
  function automatic int fold_word(input int v);
    if (v > 999) begin
      return v - 1999;
    end else if (v < -999) begin
      return v + 1999;
    end
    return v;
  endfunction

  // Apply one command to the predicted machine and return the status it reports.
  function automatic lmc_status_t run_command(input action_e act, input logic [AddrW-1:0] addr,
                                              input logic signed [WordW-1:0] wv,
                                              input logic signed [WordW-1:0] iv);
    lmc_status_t r;
    int word;
    int op;
    int opnd;
    int oval;
    bit moved;
    logic [CodeW-1:0] code;
    r = '0;
    oval = 0;
    moved = 1'b0;
    case (act)
      ActClear: begin
        foreach (mbox_model[i]) mbox_model[i] = 0;
        acc_model = 0;
        pc_model = 0;
      end
      ActLoad: begin
        if (addr < MailboxCount) mbox_model[addr] = fold_word(int'(wv));
      end
      ActStep: begin
        steps_run++;
        word = mbox_model[pc_model];
        // Negative words are skipped like no-ops.
        if (word >= 0) begin
          op = word / 100;
          opnd = word % 100;
          code = CodeBase + 10'(opnd);
          case (op)
            OpHlt: begin
              r.halted = 1'b1;
              moved = 1'b1;
              halts_seen++;
            end
            OpAdd: acc_model = fold_word(acc_model + mbox_model[opnd]);
            OpSub: acc_model = fold_word(acc_model - mbox_model[opnd]);
            OpSta: mbox_model[opnd] = acc_model;
            OpLda: acc_model = mbox_model[opnd];
            OpBra: begin
              pc_model = opnd;
              moved = 1'b1;
            end
            OpBrz: begin
              if (acc_model == 0) begin
                pc_model = opnd;
                moved = 1'b1;
              end
            end
            OpBrp: begin
              if (acc_model >= 0) begin
                pc_model = opnd;
                moved = 1'b1;
              end
            end
            OpIo: begin
              // Fixed input and output codes win over the character registers.
              if (code == CodeInp) begin
                acc_model = fold_word(int'(iv));
              end else if (code == CodeOut) begin
                r.kind = KindNum;
                oval = acc_model;
                num_outputs++;
              end else if (code == char_in_model) begin
                acc_model = fold_word(int'(iv));
              end else if (code == char_out_model) begin
                r.kind = KindChar;
                oval = acc_model;
                char_outputs++;
              end
            end
            default: ;
          endcase
        end
        if (!moved) pc_model = (pc_model + 1) % MailboxCount;
      end
      default: ;
    endcase
    r.value = WordW'(oval);
    r.pc = AddrW'(pc_model);
    r.acc = WordW'(acc_model);
    return r;
  endfunction

  // Check each status against the oldest prediction, then predict the new transaction.
  always @(posedge clk_i) begin : check_results
    lmc_status_t want;
    lmc_status_t guess;
    if (rst_ni === 1'b1) begin
      if (result_valid_o === 1'b1) begin
        checked++;
        if (expected_status_q.size() == 0) begin
          report_mismatch("unexpected result, pending count", 0, 0);
        end else begin
          want = expected_status_q.pop_front();
          if (halted_o !== want.halted) report_mismatch("halted", halted_o, want.halted);
          if (out_kind_o !== want.kind) report_mismatch("out_kind", out_kind_o, want.kind);
          if (out_value_o !== want.value) report_mismatch("out_value", out_value_o, want.value);
          if (next_pc_o !== want.pc) report_mismatch("next_pc", next_pc_o, want.pc);
          if (acc_value_o !== want.acc) report_mismatch("acc_value", acc_value_o, want.acc);
        end
      end
      if (start && !busy) begin
        accepted++;
        guess = run_command(action_e'(action_i), word_address_i, word_value_i, in_value_i);
        expected_status_q.push_back(row_q.has_want ? row_q.want : guess);
      end
    end
  end

  function automatic cmd_row_t cmd(input action_e act, input int addr, input int wv, input int iv,
                                   input bit has_want, input bit halt, input int pc,
                                   input int acc);
    cmd_row_t c;
    c = '0;
    c.action = act;
    c.addr = AddrW'(addr);
    c.wval = WordW'(wv);
    c.ival = WordW'(iv);
    c.has_want = has_want;
    c.want.halted = halt;
    c.want.pc = AddrW'(pc);
    c.want.acc = WordW'(acc);
    return c;
  endfunction

  // Random command, mostly loads near the program counter and steps that run them.
  function automatic cmd_row_t random_command();
    cmd_row_t c;
    int pick;
    int op;
    logic [CodeW-1:0] code;
    c = '0;
    c.addr = AddrW'($urandom);
    c.wval = WordW'($urandom);
    c.ival = WordW'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      c.action = ActClear;
    end else if (pick < 5) begin
      c.action = ActNone;
    end else if (pick < 45) begin
      c.action = ActLoad;
      case ($urandom_range(0, 19))
        0: ;  // keep the raw address, which may lie past the last mailbox
        1, 2: c.addr = AddrW'($urandom_range(0, MailboxCount - 1));
        default: c.addr = AddrW'((pc_model + $urandom_range(0, 4)) % MailboxCount);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          op = $urandom_range(0, 9);
          if (op == OpIo) begin
            case ($urandom_range(0, 4))
              0: code = CodeInp;
              1: code = CodeOut;
              2: code = char_in_model;
              3: code = char_out_model;
              default: code = CodeBase + 10'($urandom_range(0, 99));
            endcase
            if (code < CodeBase || code > CodeBase + 10'd99) code = CodeBase;
            c.wval = WordW'(code);
          end else begin
            c.wval = WordW'(op * 100 + $urandom_range(0, 99));
          end
        end
        6, 7: c.wval = WordW'(int'($urandom_range(0, 1998)) - 999);
        8: begin
          case ($urandom_range(0, 3))
            0: c.wval = 11'sd999;
            1: c.wval = -11'sd999;
            2: c.wval = 11'sd0;
            default: c.wval = -11'sd1;
          endcase
        end
        default: ;  // raw 11-bit word, folded by the core
      endcase
    end else begin
      c.action = ActStep;
      case ($urandom_range(0, 3))
        0, 1: c.ival = WordW'(int'($urandom_range(0, 1998)) - 999);
        2: begin
          case ($urandom_range(0, 3))
            0: c.ival = 11'sd999;
            1: c.ival = -11'sd999;
            2: c.ival = 11'sd1023;
            default: c.ival = -11'sd1024;
          endcase
        end
        default: ;
      endcase
    end
    return c;
  endfunction

  // Present one command and hold it until the core takes it.
  task automatic send_command(input cmd_row_t row);
    start <= 1'b1;
    action_i <= row.action;
    word_address_i <= row.addr;
    word_value_i <= row.wval;
    in_value_i <= row.ival;
    row_q <= row;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every predicted status has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_code_reg(input logic [1:0] idx, input logic [CodeW-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegCharIn: char_in_model = data;
      RegCharOut: char_out_model = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Bursts of back-to-back commands, some separated by random gaps or full drains.
  task automatic run_random(input int count);
    int sent;
    int burst;
    cmd_row_t c;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < count; k++) begin
        c = random_command();
        send_command(c);
        if (c.action != ActNone && !(c.action == ActLoad && c.addr >= MailboxCount)) sent++;
      end
      case ($urandom_range(0, 9))
        0: drain();
        1, 2, 3: ;
        default: idle_for($urandom_range(1, 8));
      endcase
    end
  endtask

  initial begin : stimulus
    cmd_row_t directed[$];
    logic [CodeW-1:0] in_codes[6];
    logic [CodeW-1:0] out_codes[6];
    start = 1'b0;
    action_i = ActNone;
    word_address_i = '0;
    word_value_i = '0;
    in_value_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegCharIn;
    cfg_data_i = '0;
    row_q = '0;
    errors = 0;
    accepted = 0;
    checked = 0;
    steps_run = 0;
    halts_seen = 0;
    num_outputs = 0;
    char_outputs = 0;
    foreach (mbox_model[i]) mbox_model[i] = 0;
    acc_model = 0;
    pc_model = 0;
    char_in_model = CharInReset;
    char_out_model = CharOutReset;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A short program that touches every opcode but the plain branch, the wrap of sums and inputs,
    // a negative word, an unassigned nine-hundreds code and an ignored load.
    directed.push_back(cmd(ActStep, 0, 0, 0, 1, 1, 0, 0));
    directed.push_back(cmd(ActLoad, 127, -1024, 0, 1, 0, 0, 0));
    directed.push_back(cmd(ActLoad, 0, 901, 0, 0, 0, 0, 0));
    directed.push_back(cmd(ActLoad, 1, 902, 0, 0, 0, 0, 0));
    directed.push_back(cmd(ActLoad, 2, 923, 0, 0, 0, 0, 0));
    directed.push_back(cmd(ActLoad, 3, 922, 0, 0, 0, 0, 0));
    directed.push_back(cmd(ActLoad, 4, -1024, 0, 0, 0, 0, 0));
    directed.push_back(cmd(ActLoad, 5, -1, 0, 0, 0, 0, 0));
    directed.push_back(cmd(ActLoad, 6, 150, 0, 0, 0, 0, 0));
    directed.push_back(cmd(ActLoad, 50, 999, 0, 0, 0, 0, 0));
    directed.push_back(cmd(ActLoad, 7, 250, 0, 0, 0, 0, 0));
    directed.push_back(cmd(ActLoad, 8, 351, 0, 0, 0, 0, 0));
    directed.push_back(cmd(ActLoad, 9, 551, 0, 0, 0, 0, 0));
    directed.push_back(cmd(ActLoad, 10, 713, 0, 0, 0, 0, 0));
    directed.push_back(cmd(ActLoad, 11, 820, 0, 0, 0, 0, 0));
    directed.push_back(cmd(ActStep, 0, 0, 1023, 0, 0, 0, 0));
    directed.push_back(cmd(ActStep, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(cmd(ActStep, 0, 0, -1024, 0, 0, 0, 0));
    for (int k = 0; k < 10; k++) directed.push_back(cmd(ActStep, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(cmd(ActClear, 0, 0, 0, 1, 0, 0, 0));
    directed.push_back(cmd(ActStep, 0, 0, 0, 1, 1, 0, 0));
    foreach (directed[k]) begin
      send_command(directed[k]);
      if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 3));
    end
    run_random(PhaseItems);

    // Register settings: both extremes, overlap with the fixed codes,
    // one shared code, codes that never match, and a random pair.
    in_codes = '{10'd900, 10'd999, CodeInp, 10'd950, 10'd0, 10'd0};
    out_codes = '{10'd999, 10'd900, CodeOut, 10'd950, 10'd1023, 10'd0};
    in_codes[5] = CodeBase + 10'($urandom_range(0, 99));
    out_codes[5] = CodeBase + 10'($urandom_range(0, 99));
    for (int p = 0; p < 6; p++) begin
      drain();
      write_code_reg(RegCharIn, in_codes[p]);
      write_code_reg(RegCharOut, out_codes[p]);
      if (p == 4) write_code_reg(RegUnused, 10'($urandom));
      run_random(PhaseItems);
    end
    drain();

    if (expected_status_q.size() != 0) begin
      report_mismatch("results never seen, count", 0, expected_status_q.size());
    end
    $display("run covered %0d commands and %0d checked results with %0d mismatches",
             accepted, checked, errors);
    $display("%0d instructions run, %0d halts, %0d number and %0d character outputs",
             steps_run, halts_seen, num_outputs, char_outputs);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a core that stops responding.
  initial begin : watchdog
    #5_000_000;
    $display("timeout: the core stopped taking commands or returning results");
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

/* little_man_computer_core.f */
rtl/lmc_pkg.sv
rtl/lmc_ram.sv
rtl/lmc_ctrl.sv
rtl/lmc_datapath.sv
rtl/little_man_computer_core.sv
tb/testbench.sv
